@@ design/ghwo_pkg.sv @@
// Shared types, constants and tables for the gyro-heading wheel odometry core.
`default_nettype none

package ghwo_pkg;

    // Tunable precision
    localparam int CORDIC_STEPS  = 16;   // 8..24
    localparam int FRACTION_BITS = 16;   // 8..24

    localparam int ATAN_LEN   = 24;
    localparam int CORD_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // Field widths
    localparam int REV_W = 32;
    localparam int IPR_W = 24;
    localparam int POS_W = 40;
    localparam int ACC_W = 48;

    // Datapath widths
    localparam int CNT_W   = 5;
    localparam int ANG_W   = 35;
    localparam int XY_W    = FRACTION_BITS + 3;
    localparam int TRIG_W  = FRACTION_BITS + 2;
    localparam int MUL_A_W = POS_W + 1;
    localparam int MUL_B_W = (TRIG_W > IPR_W + 2) ? TRIG_W : IPR_W + 2;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [IPR_W-1:0] IPR_RESET = 24'd823550;

    // Heading reduction: 360 degrees in Q16.16, and a bias of 128 turns that
    // lifts any negative 32-bit heading into the non-negative range.
    localparam logic [31:0] HEAD_MOD  = 32'd23592960;
    localparam logic [31:0] HEAD_BIAS = 32'd3019898880;
    localparam int          RED_STEPS = 7;

    // Angles in degrees, Q.24
    localparam logic signed [ANG_W-1:0] DEG90  = 35'sd1509949440;
    localparam logic signed [ANG_W-1:0] DEG180 = 35'sd3019898880;
    localparam logic signed [ANG_W-1:0] DEG360 = 35'sd6039797760;

    // CORDIC gain, prescaled to the fraction width with rounding
    localparam longint GAIN_Q32  = 64'd2608131496;
    localparam longint GAIN_INIT =
        (GAIN_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
    localparam logic signed [XY_W-1:0] TRIG_ONE = XY_W'(longint'(1) << FRACTION_BITS);

    typedef struct packed {
        logic signed [REV_W-1:0] right_revs;
        logic signed [REV_W-1:0] left_revs;
        logic signed [REV_W-1:0] heading_deg;
    } t_in_word;

    typedef struct packed {
        logic signed [ACC_W-1:0] x_position;
        logic signed [ACC_W-1:0] y_position;
        logic signed [POS_W-1:0] step_distance;
    } t_out_word;

    // Arctangent of 2^-i in degrees, Q.24
    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [CNT_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(754974720);
            5'd1:    v = ANG_W'(445687602);
            5'd2:    v = ANG_W'(235489088);
            5'd3:    v = ANG_W'(119537938);
            5'd4:    v = ANG_W'(60000934);
            5'd5:    v = ANG_W'(30029717);
            5'd6:    v = ANG_W'(15018523);
            5'd7:    v = ANG_W'(7509720);
            5'd8:    v = ANG_W'(3754917);
            5'd9:    v = ANG_W'(1877466);
            5'd10:   v = ANG_W'(938734);
            5'd11:   v = ANG_W'(469367);
            5'd12:   v = ANG_W'(234684);
            5'd13:   v = ANG_W'(117342);
            5'd14:   v = ANG_W'(58671);
            5'd15:   v = ANG_W'(29335);
            5'd16:   v = ANG_W'(14668);
            5'd17:   v = ANG_W'(7334);
            5'd18:   v = ANG_W'(3667);
            5'd19:   v = ANG_W'(1833);
            5'd20:   v = ANG_W'(917);
            5'd21:   v = ANG_W'(458);
            5'd22:   v = ANG_W'(229);
            5'd23:   v = ANG_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/gyro_heading_wheel_odometry_core.sv @@
// Top level of the gyro-heading wheel odometry core: sequencer and shared datapath.
`default_nettype none

// Dead-reckoning odometry for a differential-drive base. Each input word holds
// both wheel positions (revolutions, Q16.16; the left wheel is mounted
// reversed) and a gyro heading (degrees, Q16.16, any number of turns). The
// core scales both wheels to inches with the inches_per_rev register (Q8.16,
// reset 4*pi), takes the mean of the two wheel deltas as the step distance,
// reduces the heading modulo 360 degrees, gets cosine and sine from an
// iterative CORDIC that works in degrees, and adds distance*cos to y and
// -distance*sin to x, both saturating at 48 bits. Each input word yields
// exactly one output word {x, y, distance}. One item is processed at a time:
// the input is ready only while the core is idle, and an item occupies it from
// acceptance to the next ready, which waits until the previous result has been
// taken. The time is set by the CORDIC loop, one rotation per cycle through a
// single shift/add unit, plus the stepwise conditional subtraction for the
// heading modulo and four uses of the single shared multiplier (two wheel
// scalings, two trig products), overlapped where possible. The result sits in
// an output register, so the next word is taken while it waits. Write
// inches_per_rev only while the core is idle; writes take effect at once.
module gyro_heading_wheel_odometry_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  ghwo_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output ghwo_pkg::t_out_word                o_out_word,
    input  wire                                i_cfg_we,
    input  wire  [ghwo_pkg::IPR_W-1:0]         i_cfg_wdata
);

    localparam int FB      = ghwo_pkg::FRACTION_BITS;
    localparam int POS_W   = ghwo_pkg::POS_W;
    localparam int ACC_W   = ghwo_pkg::ACC_W;
    localparam int ANG_W   = ghwo_pkg::ANG_W;
    localparam int XY_W    = ghwo_pkg::XY_W;
    localparam int TRIG_W  = ghwo_pkg::TRIG_W;
    localparam int CNT_W   = ghwo_pkg::CNT_W;
    localparam int MUL_A_W = ghwo_pkg::MUL_A_W;
    localparam int MUL_B_W = ghwo_pkg::MUL_B_W;
    localparam int MUL_P_W = ghwo_pkg::MUL_P_W;

    typedef enum logic [3:0] {
        ST_IDLE,   // wait for an input word
        ST_RED,    // heading modulo, wheel scaling, distance
        ST_FOLD,   // fold the angle into [-90, 90] and seed the CORDIC
        ST_ROT,    // one CORDIC rotation per cycle
        ST_CLAMP,  // clamp and unfold cos/sin
        ST_MULC,   // distance * cos
        ST_MULS,   // distance * sin, update y
        ST_ACCX,   // update x
        ST_DONE    // hand the result to the output register
    } t_state;

    // Sequencer and configuration
    t_state                    r_state,  n_state;
    logic [CNT_W-1:0]          r_cnt,    n_cnt;
    logic [ghwo_pkg::IPR_W-1:0] r_ipr,   n_ipr;

    // Item payload
    ghwo_pkg::t_in_word        r_in,     n_in;
    logic [31:0]               r_v,      n_v;
    logic signed [POS_W-1:0]   r_rpos,   n_rpos;
    logic signed [POS_W-1:0]   r_lpos,   n_lpos;
    logic signed [POS_W-1:0]   r_dist,   n_dist;
    logic signed [ANG_W-1:0]   r_ang,    n_ang;
    logic                      r_flip,   n_flip;
    logic signed [XY_W-1:0]    r_x,      n_x;
    logic signed [XY_W-1:0]    r_y,      n_y;
    logic signed [TRIG_W-1:0]  r_cs,     n_cs;
    logic signed [TRIG_W-1:0]  r_sn,     n_sn;
    logic signed [MUL_P_W-1:0] r_prod;

    // Odometry state
    logic signed [POS_W-1:0]   r_prev_r, n_prev_r;
    logic signed [POS_W-1:0]   r_prev_l, n_prev_l;
    logic signed [ACC_W-1:0]   r_x_acc,  n_x_acc;
    logic signed [ACC_W-1:0]   r_y_acc,  n_y_acc;

    // Output register
    logic                      r_out_valid, n_out_valid;
    ghwo_pkg::t_out_word       r_out_word,  n_out_word;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    // Datapath helpers
    logic signed [MUL_P_W-1:0] wheel_r, wheel_l, trig_sum;
    logic        [POS_W:0]     trig_mag;
    logic signed [POS_W+1:0]   trig_term;
    logic                      trig_neg;
    logic signed [MUL_A_W-1:0] dist_mag;
    logic signed [TRIG_W-1:0]  cs_mag, sn_mag;
    logic signed [POS_W+1:0]   dsum, dhalf;
    logic [31:0]               mod_k;
    logic [32:0]               red_try;
    logic signed [ANG_W-1:0]   ang0, ang1;
    logic signed [XY_W-1:0]    xs, ys, cx, cy;
    logic signed [ACC_W:0]     acc_sum;
    logic                      in_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign in_acc      = i_in_valid && o_in_ready;

    // Operand selection for the one multiplier; register the product.
    assign dist_mag = r_dist[POS_W-1] ? -MUL_A_W'(r_dist) : MUL_A_W'(r_dist);
    assign cs_mag   = r_cs[TRIG_W-1] ? -r_cs : r_cs;
    assign sn_mag   = r_sn[TRIG_W-1] ? -r_sn : r_sn;

    always_comb begin
        case (r_state)
            ST_RED: begin
                // right wheel first, then left
                mul_a = (r_cnt == CNT_W'(ghwo_pkg::RED_STEPS - 1))
                      ? MUL_A_W'(r_in.right_revs) : MUL_A_W'(r_in.left_revs);
                mul_b = MUL_B_W'({1'b0, r_ipr});
            end
            ST_MULC: begin
                mul_a = dist_mag;
                mul_b = MUL_B_W'(cs_mag);
            end
            default: begin
                mul_a = dist_mag;
                mul_b = MUL_B_W'(sn_mag);
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // Round wheel products to Q.16 (floor after adding one half).
    assign wheel_r = r_prod + MUL_P_W'(32768);
    assign wheel_l = -r_prod + MUL_P_W'(32768);

    // Round a trig product half away from zero; sign comes from the operands.
    assign trig_sum  = r_prod + (MUL_P_W'(1) <<< (FB - 1));
    assign trig_mag  = trig_sum[FB+POS_W:FB];
    assign trig_neg  = (r_state == ST_MULS) ? (r_dist[POS_W-1] ^ r_cs[TRIG_W-1])
                                            : (r_dist[POS_W-1] ^ r_sn[TRIG_W-1]);
    assign trig_term = trig_neg ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});

    // Mean of both wheel deltas, floor halved
    assign dsum  = (POS_W+2)'(r_rpos) - (POS_W+2)'(r_prev_r)
                 + (POS_W+2)'(r_lpos) - (POS_W+2)'(r_prev_l);
    assign dhalf = dsum >>> 1;

    // Heading modulo: conditional subtract of 360 deg shifted by the step count
    assign mod_k   = ghwo_pkg::HEAD_MOD << r_cnt;
    assign red_try = {1'b0, r_v} - {1'b0, mod_k};

    // Angle in Q.24 degrees and its first fold into (-180, 180]
    assign ang0 = $signed({2'b00, r_v[24:0], 8'b0});
    assign ang1 = (ang0 > ghwo_pkg::DEG180) ? ang0 - ghwo_pkg::DEG360 : ang0;

    // Shared CORDIC shifter
    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;

    // Clamp to [-1, 1]
    assign cx = (r_x > ghwo_pkg::TRIG_ONE) ? ghwo_pkg::TRIG_ONE
              : (r_x < -ghwo_pkg::TRIG_ONE) ? -ghwo_pkg::TRIG_ONE : r_x;
    assign cy = (r_y > ghwo_pkg::TRIG_ONE) ? ghwo_pkg::TRIG_ONE
              : (r_y < -ghwo_pkg::TRIG_ONE) ? -ghwo_pkg::TRIG_ONE : r_y;

    // Accumulator adder: add for y, subtract for x
    assign acc_sum = (r_state == ST_MULS)
                   ? (ACC_W+1)'(r_y_acc) + (ACC_W+1)'(trig_term)
                   : (ACC_W+1)'(r_x_acc) - (ACC_W+1)'(trig_term);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ipr       = i_cfg_we ? i_cfg_wdata : r_ipr;
        n_in        = r_in;
        n_v         = r_v;
        n_rpos      = r_rpos;
        n_lpos      = r_lpos;
        n_dist      = r_dist;
        n_ang       = r_ang;
        n_flip      = r_flip;
        n_x         = r_x;
        n_y         = r_y;
        n_cs        = r_cs;
        n_sn        = r_sn;
        n_prev_r    = r_prev_r;
        n_prev_l    = r_prev_l;
        n_x_acc     = r_x_acc;
        n_y_acc     = r_y_acc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_in    = i_in_word;
                    // lift negative headings by 128 turns
                    n_v     = i_in_word.heading_deg[31]
                            ? 32'(i_in_word.heading_deg) + ghwo_pkg::HEAD_BIAS
                            : 32'(i_in_word.heading_deg);
                    n_cnt   = CNT_W'(ghwo_pkg::RED_STEPS - 1);
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                if (!red_try[32]) begin
                    n_v = red_try[31:0];
                end
                if (r_cnt == CNT_W'(ghwo_pkg::RED_STEPS - 2)) begin
                    n_rpos = wheel_r[16+POS_W-1:16];
                end
                if (r_cnt == CNT_W'(ghwo_pkg::RED_STEPS - 3)) begin
                    n_lpos = wheel_l[16+POS_W-1:16];
                end
                if (r_cnt == CNT_W'(ghwo_pkg::RED_STEPS - 4)) begin
                    // saturate the distance to 40 bits, advance wheel history
                    if (dhalf[POS_W+1] == dhalf[POS_W] && dhalf[POS_W] == dhalf[POS_W-1]) begin
                        n_dist = dhalf[POS_W-1:0];
                    end else begin
                        n_dist = dhalf[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}}
                                                : {1'b0, {(POS_W-1){1'b1}}};
                    end
                    n_prev_r = r_rpos;
                    n_prev_l = r_lpos;
                end
                if (r_cnt == '0) begin
                    n_state = ST_FOLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FOLD: begin
                if (ang1 > ghwo_pkg::DEG90) begin
                    n_ang  = ang1 - ghwo_pkg::DEG180;
                    n_flip = 1'b1;
                end else if (ang1 < -ghwo_pkg::DEG90) begin
                    n_ang  = ang1 + ghwo_pkg::DEG180;
                    n_flip = 1'b1;
                end else begin
                    n_ang  = ang1;
                    n_flip = 1'b0;
                end
                n_x     = XY_W'(ghwo_pkg::GAIN_INIT);
                n_y     = '0;
                n_cnt   = '0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (!r_ang[ANG_W-1]) begin
                    n_x   = r_x - ys;
                    n_y   = r_y + xs;
                    n_ang = r_ang - ghwo_pkg::atan_q24(r_cnt);
                end else begin
                    n_x   = r_x + ys;
                    n_y   = r_y - xs;
                    n_ang = r_ang + ghwo_pkg::atan_q24(r_cnt);
                end
                if (r_cnt == CNT_W'(ghwo_pkg::CORD_ITERS - 1)) begin
                    n_state = ST_CLAMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CLAMP: begin
                n_cs    = r_flip ? -TRIG_W'(cx) : TRIG_W'(cx);
                n_sn    = r_flip ? -TRIG_W'(cy) : TRIG_W'(cy);
                n_state = ST_MULC;
            end
            ST_MULC: begin
                n_state = ST_MULS;
            end
            ST_MULS: begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
                    n_y_acc = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    n_y_acc = acc_sum[ACC_W-1:0];
                end
                n_state = ST_ACCX;
            end
            ST_ACCX: begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
                    n_x_acc = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    n_x_acc = acc_sum[ACC_W-1:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid              = 1'b1;
                    n_out_word.x_position    = r_x_acc;
                    n_out_word.y_position    = r_y_acc;
                    n_out_word.step_distance = r_dist;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // payload: no reset needed
        r_in       <= n_in;
        r_v        <= n_v;
        r_rpos     <= n_rpos;
        r_lpos     <= n_lpos;
        r_dist     <= n_dist;
        r_ang      <= n_ang;
        r_flip     <= n_flip;
        r_x        <= n_x;
        r_y        <= n_y;
        r_cs       <= n_cs;
        r_sn       <= n_sn;
        r_prod     <= mul_p;
        r_out_word <= n_out_word;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_ipr       <= ghwo_pkg::IPR_RESET;
            r_prev_r    <= '0;
            r_prev_l    <= '0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ipr       <= n_ipr;
            r_prev_r    <= n_prev_r;
            r_prev_l    <= n_prev_l;
            r_x_acc     <= n_x_acc;
            r_y_acc     <= n_y_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // A new word never produces a result in the very next cycle.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result raised right after accept");

    // Results appear only on leaving the hand-off state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside hand-off");

    // The rotation counter stays within the arctangent table in use.
    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROT |-> r_cnt < CNT_W'(ghwo_pkg::CORD_ITERS))
        else $error("CORDIC step out of range");

    // Accumulators change only in their update cycles.
    a_y_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_y_acc) |-> $past(r_state) == ST_MULS)
        else $error("y accumulator changed outside its update");

    a_x_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_x_acc) |-> $past(r_state) == ST_ACCX)
        else $error("x accumulator changed outside its update");

    // Cosine stays clamped to [-1, 1] while it feeds the multiplier.
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MULC |-> (XY_W'(r_cs) <= ghwo_pkg::TRIG_ONE
                                && XY_W'(r_cs) >= -ghwo_pkg::TRIG_ONE))
        else $error("cosine outside unit range");

endmodule

`default_nettype wire
